[src/udw_pkg.sv]
// Shared types, status codes and code point classification functions for the UTF-8 width decoder.
package udw_pkg;

   localparam int TOTAL_WIDTH_BITS_DEF = 16;
   localparam int CP_BITS              = 21;
   localparam int TOTAL_OUT_BITS       = 16;
   localparam logic [1:0] QUEUE_DEPTH  = 2'd2;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_CONTROL    = 3'd1,
      ST_INCOMPLETE = 3'd2,
      ST_OVERLONG   = 3'd3,
      ST_SURROGATE  = 3'd4,
      ST_RANGE      = 3'd5,
      ST_BADLEAD    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      K_ASCII,
      K_LEAD2,
      K_LEAD3,
      K_LEAD4,
      K_CONT,
      K_BAD
   } byte_kind_type;

   typedef enum logic [1:0] {
      SEQ_ASCII = 2'd0,
      SEQ_2BYTE = 2'd1,
      SEQ_3BYTE = 2'd2,
      SEQ_4BYTE = 2'd3
   } seq_class_type;

   localparam logic [1:0] COL_ZERO    = 2'd0;
   localparam logic [1:0] COL_ONE     = 2'd1;
   localparam logic [1:0] COL_TWO     = 2'd2;
   localparam logic [1:0] COL_CONTROL = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } udw_req_type;

   typedef struct packed {
      logic                  has_codepoint;
      logic [CP_BITS-1:0]    codepoint;
      logic [1:0]            char_width;
      status_type            status;
      logic [TOTAL_OUT_BITS-1:0] total_width;
      logic                  done_res;
   } udw_rsp_type;

   typedef struct packed {
      byte_kind_type kind;
      logic [6:0]    bits;
      logic          last;
   } udw_item_type;

   function automatic logic in_span(logic [CP_BITS-1:0] c, logic [CP_BITS-1:0] lo,
                                    logic [CP_BITS-1:0] hi);
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic logic [1:0] char_columns(logic [CP_BITS-1:0] c);
      logic [1:0] cols;
      cols = COL_ONE;
      if ((c < 21'h20) || in_span(c, 21'h7F, 21'h9F)) begin
         cols = COL_CONTROL;
      end else if (in_span(c, 21'h300, 21'h36F) || in_span(c, 21'h1AB0, 21'h1AFF) ||
                   in_span(c, 21'h1DC0, 21'h1DFF) || in_span(c, 21'h20D0, 21'h20FF) ||
                   in_span(c, 21'hFE20, 21'hFE2F)) begin
         cols = COL_ZERO;
      end else if (in_span(c, 21'h1100, 21'h115F) || in_span(c, 21'h2329, 21'h232A) ||
                   in_span(c, 21'h2E80, 21'hA4CF) || in_span(c, 21'hAC00, 21'hD7A3) ||
                   in_span(c, 21'hF900, 21'hFAFF) || in_span(c, 21'hFE10, 21'hFE19) ||
                   in_span(c, 21'hFE30, 21'hFE6F) || in_span(c, 21'hFF00, 21'hFF60) ||
                   in_span(c, 21'hFFE0, 21'hFFE6) || in_span(c, 21'h20000, 21'h2FFFD) ||
                   in_span(c, 21'h30000, 21'h3FFFD)) begin
         cols = COL_TWO;
      end
      return cols;
   endfunction

   function automatic status_type check_seq(seq_class_type cls, logic [CP_BITS-1:0] c);
      status_type st;
      st = ST_OK;
      case (cls)
         SEQ_2BYTE: begin
            if (c < 21'h80) st = ST_OVERLONG;
         end
         SEQ_3BYTE: begin
            if (c < 21'h800) st = ST_OVERLONG;
            else if (in_span(c, 21'hD800, 21'hDFFF)) st = ST_SURROGATE;
         end
         SEQ_4BYTE: begin
            if (c < 21'h10000) st = ST_OVERLONG;
            else if (c > 21'h10FFFF) st = ST_RANGE;
         end
         default: st = ST_OK;
      endcase
      return st;
   endfunction

endpackage

[src/udw_front.sv]
// Front end: byte classification and the short queue that feeds the decoder.
module udw_front
   import udw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  udw_req_type  req_data,
   output logic         fq_valid,
   output udw_item_type fq_item,
   input  logic         fq_take
);

   udw_item_type slot_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff;
   logic         wr_ptr_in;
   logic         rd_ptr_ff;
   logic         rd_ptr_in;
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   udw_item_type item_in;
   logic         do_write;
   logic         do_read;

   always_comb begin
      item_in.last = req_data.last;
      item_in.bits = req_data.data_byte[6:0];
      if (!req_data.data_byte[7]) begin
         item_in.kind = K_ASCII;
      end else if (req_data.data_byte[7:6] == 2'b10) begin
         item_in.kind = K_CONT;
      end else if (req_data.data_byte[7:5] == 3'b110) begin
         item_in.kind = K_LEAD2;
      end else if (req_data.data_byte[7:4] == 4'b1110) begin
         item_in.kind = K_LEAD3;
      end else if (req_data.data_byte[7:3] == 5'b11110) begin
         item_in.kind = K_LEAD4;
      end else begin
         item_in.kind = K_BAD;
      end
   end

   assign full     = (count_ff == QUEUE_DEPTH);
   assign fq_valid = (count_ff != 2'd0);
   assign fq_item  = slot_ff[rd_ptr_ff];
   assign do_write = push && !full;
   assign do_read  = fq_take && fq_valid;

   always_comb begin
      wr_ptr_in = do_write ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_read ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_write && !do_read) begin
         count_in = count_ff + 2'd1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

[src/udw_back.sv]
// Back end: sequence decoding, validation, width accounting and the result queue.
module udw_back
   import udw_pkg::*;
#(
   parameter int TOTAL_WIDTH_BITS = TOTAL_WIDTH_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fq_valid,
   input  udw_item_type fq_item,
   output logic         fq_take,
   output logic         empty,
   input  logic         pop,
   output udw_rsp_type  rsp_data
);

   localparam int EW = (TOTAL_WIDTH_BITS > TOTAL_OUT_BITS) ? TOTAL_WIDTH_BITS : TOTAL_OUT_BITS;

   logic [1:0]                  bytes_left_ff;
   logic [1:0]                  bytes_left_in;
   seq_class_type               seq_class_ff;
   seq_class_type               seq_class_in;
   logic [CP_BITS-1:0]          cp_accum_ff;
   logic [CP_BITS-1:0]          cp_accum_in;
   logic [TOTAL_WIDTH_BITS-1:0] width_sum_ff;
   logic [TOTAL_WIDTH_BITS-1:0] width_sum_in;
   status_type                  sticky_ff;
   status_type                  sticky_in;

   logic                        emit;
   logic                        done_cp;
   logic                        has;
   logic [CP_BITS-1:0]          cp_out;
   logic [1:0]                  w_out;
   logic [1:0]                  cols;
   status_type                  chk;
   logic [TOTAL_WIDTH_BITS:0]   sum_wide;
   logic [EW-1:0]               sum_ext;
   udw_rsp_type                 rsp_in;
   logic                        step;

   udw_rsp_type                 oq_ff [QUEUE_DEPTH];
   logic                        oq_wr_ff;
   logic                        oq_rd_ff;
   logic [1:0]                  oq_count_ff;
   logic [1:0]                  oq_count_in;
   logic                        oq_write;
   logic                        oq_read;

   assign step    = fq_valid && (oq_count_ff != QUEUE_DEPTH);
   assign fq_take = step;

   always_comb begin
      bytes_left_in = bytes_left_ff;
      seq_class_in  = seq_class_ff;
      cp_accum_in   = cp_accum_ff;
      width_sum_in  = width_sum_ff;
      sticky_in     = sticky_ff;
      emit          = 1'b0;
      done_cp       = 1'b0;
      has           = 1'b0;
      cp_out        = '0;
      w_out         = COL_ZERO;
      cols          = COL_ZERO;
      chk           = ST_OK;
      sum_wide      = '0;
      if (sticky_ff == ST_OK) begin
         if (bytes_left_ff == 2'd0) begin
            case (fq_item.kind)
               K_ASCII: begin
                  cp_accum_in  = CP_BITS'(fq_item.bits);
                  seq_class_in = SEQ_ASCII;
                  done_cp      = 1'b1;
               end
               K_LEAD2: begin
                  cp_accum_in   = CP_BITS'(fq_item.bits[4:0]);
                  bytes_left_in = 2'd1;
                  seq_class_in  = SEQ_2BYTE;
               end
               K_LEAD3: begin
                  cp_accum_in   = CP_BITS'(fq_item.bits[3:0]);
                  bytes_left_in = 2'd2;
                  seq_class_in  = SEQ_3BYTE;
               end
               K_LEAD4: begin
                  cp_accum_in   = CP_BITS'(fq_item.bits[2:0]);
                  bytes_left_in = 2'd3;
                  seq_class_in  = SEQ_4BYTE;
               end
               default: begin
                  sticky_in     = ST_BADLEAD;
                  bytes_left_in = 2'd0;
                  seq_class_in  = SEQ_ASCII;
                  cp_accum_in   = '0;
                  emit          = 1'b1;
               end
            endcase
         end else if (fq_item.kind == K_CONT) begin
            cp_accum_in   = {cp_accum_ff[CP_BITS-7:0], fq_item.bits[5:0]};
            bytes_left_in = bytes_left_ff - 2'd1;
            done_cp       = (bytes_left_ff == 2'd1);
         end else begin
            sticky_in     = ST_INCOMPLETE;
            bytes_left_in = 2'd0;
            seq_class_in  = SEQ_ASCII;
            cp_accum_in   = '0;
            emit          = 1'b1;
         end

         if (done_cp) begin
            chk  = check_seq(seq_class_in, cp_accum_in);
            emit = 1'b1;
            if (chk != ST_OK) begin
               sticky_in = chk;
            end else begin
               cols   = char_columns(cp_accum_in);
               has    = 1'b1;
               cp_out = cp_accum_in;
               if (cols == COL_CONTROL) begin
                  sticky_in = ST_CONTROL;
               end else begin
                  w_out    = cols;
                  sum_wide = {1'b0, width_sum_ff} + (TOTAL_WIDTH_BITS + 1)'(cols);
                  width_sum_in = sum_wide[TOTAL_WIDTH_BITS] ? {TOTAL_WIDTH_BITS{1'b1}}
                                                            : sum_wide[TOTAL_WIDTH_BITS-1:0];
               end
            end
            bytes_left_in = 2'd0;
            seq_class_in  = SEQ_ASCII;
            cp_accum_in   = '0;
         end

         if (fq_item.last && (bytes_left_in != 2'd0) && (sticky_in == ST_OK)) begin
            sticky_in     = ST_INCOMPLETE;
            bytes_left_in = 2'd0;
            seq_class_in  = SEQ_ASCII;
            cp_accum_in   = '0;
         end
      end
      if (fq_item.last) begin
         emit = 1'b1;
      end
   end

   always_comb begin
      sum_ext              = EW'(width_sum_in);
      rsp_in.has_codepoint = has;
      rsp_in.codepoint     = cp_out;
      rsp_in.char_width    = w_out;
      rsp_in.status        = sticky_in;
      rsp_in.total_width   = (sum_ext > EW'({TOTAL_OUT_BITS{1'b1}})) ? {TOTAL_OUT_BITS{1'b1}}
                                                                      : sum_ext[TOTAL_OUT_BITS-1:0];
      rsp_in.done_res      = fq_item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 2'd0;
         seq_class_ff  <= SEQ_ASCII;
         cp_accum_ff   <= '0;
         width_sum_ff  <= '0;
         sticky_ff     <= ST_OK;
      end else if (step) begin
         if (fq_item.last) begin
            bytes_left_ff <= 2'd0;
            seq_class_ff  <= SEQ_ASCII;
            cp_accum_ff   <= '0;
            width_sum_ff  <= '0;
            sticky_ff     <= ST_OK;
         end else begin
            bytes_left_ff <= bytes_left_in;
            seq_class_ff  <= seq_class_in;
            cp_accum_ff   <= cp_accum_in;
            width_sum_ff  <= width_sum_in;
            sticky_ff     <= sticky_in;
         end
      end
   end

   assign empty    = (oq_count_ff == 2'd0);
   assign rsp_data = oq_ff[oq_rd_ff];
   assign oq_write = step && emit;
   assign oq_read  = pop && !empty;

   always_comb begin
      oq_count_in = oq_count_ff;
      if (oq_write && !oq_read) begin
         oq_count_in = oq_count_ff + 2'd1;
      end else if (oq_read && !oq_write) begin
         oq_count_in = oq_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= 2'd0;
      end else begin
         oq_wr_ff    <= oq_write ? ~oq_wr_ff : oq_wr_ff;
         oq_rd_ff    <= oq_read ? ~oq_rd_ff : oq_rd_ff;
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_write) begin
         oq_ff[oq_wr_ff] <= rsp_in;
      end
   end

endmodule

[src/utf8_decode_display_width.sv]
// Top level of the UTF-8 decoder with display width accounting.
//
//   Channel   Ports                      Transfer when
//   request   push, full, req_data       push high and full low
//   response  pop, empty, rsp_data       pop high and empty low
//
// One byte is decoded per cycle when both sides keep moving; the decoder state in the
// back end is updated once per byte and sets that figure.
// A byte waits in the byte queue before any result for it enters the result queue; each queue holds two entries.
// Reset is synchronous and clears both queues and all decoder state; no clearing pass is needed.
// A stalled consumer fills the result queue, then the byte queue, and only then raises full.
module utf8_decode_display_width
   import udw_pkg::*;
#(
   parameter int TOTAL_WIDTH_BITS = TOTAL_WIDTH_BITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  udw_req_type req_data,
   output logic        empty,
   input  logic        pop,
   output udw_rsp_type rsp_data
);

   logic         fq_valid;
   logic         fq_take;
   udw_item_type fq_item;

   udw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .fq_valid (fq_valid),
      .fq_item  (fq_item),
      .fq_take  (fq_take)
   );

   udw_back #(
      .TOTAL_WIDTH_BITS (TOTAL_WIDTH_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .fq_valid (fq_valid),
      .fq_item  (fq_item),
      .fq_take  (fq_take),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
